// File: hw/rtl/pidl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list unit.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic do_insert;
        logic do_delete;
    } cell_cmd_t;

endpackage : pidl_pkg
`default_nettype wire

// File: hw/rtl/positional_insert_delete_list_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit
// Ordered list of signed 32-bit values with insert and delete by position.
// ----------------------------------------------------------------------------
// Usage: each input beat on the s_ channel is one list operation. s_tuser
// carries the opcode (insert or delete); s_tdata carries the position and,
// for inserts, the value. Every accepted beat produces exactly one result
// beat on the m_ channel with a status code in m_tuser and the removed
// value and the new list length in m_tdata.
// The list lives in a chain of DEPTH cells. An insert shifts every cell at
// and after the position one place toward the end all together; a
// delete shifts the later cells one place toward the front. A failed
// operation (bad position, empty or full list) leaves the chain untouched.
// The result beat follows in the cycle after its input beat, from the
// result register, and one operation is accepted per cycle while the
// receiver keeps taking results.
// Reset clears the entry count and the result valid flag; cell contents
// are not cleared, since only cells below the count are ever read.
// When the receiver stalls, the held result stays in the output register
// and s_tready drops, so no further operation is accepted until the
// result beat is taken.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit #(
    parameter int DEPTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [4:0] position, [36:5] value, [39:37] zero
    input  wire  [0:0]  s_tuser,   // [0] opcode
    // Result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] length, [39:37] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    // Count must hold DEPTH itself; positions are compared at a width that
    // covers both the 5-bit position field and the count.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic                          in_opcode;
    logic [pidl_pkg::POS_W-1:0]    in_position;
    logic [pidl_pkg::VAL_W-1:0]    in_value;
    logic                          accept;

    assign in_opcode   = s_tuser[0];
    assign in_position = s_tdata[4:0];
    assign in_value    = s_tdata[36:5];

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    pidl_pkg::status_t             m_status_reg;
    logic [pidl_pkg::VAL_W-1:0]    m_removed_reg;
    logic [pidl_pkg::LEN_W-1:0]    m_length_reg;

    logic [PW-1:0]                 pos_ext;
    logic [PW-1:0]                 count_ext;
    pidl_pkg::status_t             op_status;
    logic                          insert_ok;
    logic                          delete_ok;
    pidl_pkg::cell_cmd_t           cmd;

    // The result register decouples the two sides: a new beat is taken
    // whenever the slot is empty or is being drained this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_ext   = PW'(in_position);
    assign count_ext = PW'(count_reg);

    // Insert checks the position before fullness; delete checks emptiness
    // before the position.
    always_comb begin
        op_status = pidl_pkg::ST_OK;
        if (in_opcode == pidl_pkg::OP_INSERT) begin
            priority if (pos_ext > count_ext) begin
                op_status = pidl_pkg::ST_INVALID;
            end else if (count_reg == FULL_COUNT) begin
                op_status = pidl_pkg::ST_FULL;
            end else begin
                op_status = pidl_pkg::ST_OK;
            end
        end else begin
            priority if (count_reg == '0) begin
                op_status = pidl_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
                op_status = pidl_pkg::ST_INVALID;
            end else begin
                op_status = pidl_pkg::ST_OK;
            end
        end
    end

    assign insert_ok = accept && (in_opcode == pidl_pkg::OP_INSERT)
                       && (op_status == pidl_pkg::ST_OK);
    assign delete_ok = accept && (in_opcode == pidl_pkg::OP_DELETE)
                       && (op_status == pidl_pkg::ST_OK);

    assign cmd.do_insert = insert_ok;
    assign cmd.do_delete = delete_ok;

    always_comb begin
        count_next = count_reg;
        priority if (insert_ok) begin
            count_next = count_reg + CW'(1);
        end else if (delete_ok) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    logic [pidl_pkg::VAL_W-1:0] cell_data [DEPTH];
    logic [pidl_pkg::VAL_W-1:0] cell_hit  [DEPTH];
    logic [pidl_pkg::VAL_W-1:0] hit_value;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [pidl_pkg::VAL_W-1:0] left_in;
        logic [pidl_pkg::VAL_W-1:0] right_in;

        // The chain ends feed zeros; those values only land in cells that
        // are above the count and are never read.
        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_left
            assign left_in = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_right
            assign right_in = cell_data[i+1];
        end

        pidl_cell #(
            .INDEX (i),
            .PW    (PW)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .pos        (pos_ext),
            .ins_value  (in_value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // Only the addressed cell drives a nonzero hit, so an OR gathers it.
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_value = hit_value | cell_hit[i];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg  <= op_status;
            m_removed_reg <= delete_ok ? hit_value : '0;
            m_length_reg  <= pidl_pkg::LEN_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_length_reg, m_removed_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds list depth");

    a_insert_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        insert_ok |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("successful insert did not grow the list");

    a_fail_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op_status != pidl_pkg::ST_OK)) |=> $stable(count_reg))
        else $error("failed operation changed the entry count");

    a_removed_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != pidl_pkg::ST_OK)) |-> (m_removed_reg == '0))
        else $error("failed operation reported a removed value");

    a_result_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted beat did not produce a result");

endmodule : positional_insert_delete_list_unit
`default_nettype wire

// File: hw/rtl/pidl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds an entry and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module pidl_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 5
) (
    input  wire                              aclk,
    input  wire  pidl_pkg::cell_cmd_t        cmd,
    input  wire  [PW-1:0]                    pos,
    input  wire  [pidl_pkg::VAL_W-1:0]       ins_value,
    input  wire  [pidl_pkg::VAL_W-1:0]       left_data,
    input  wire  [pidl_pkg::VAL_W-1:0]       right_data,
    output logic [pidl_pkg::VAL_W-1:0]       data,
    output logic [pidl_pkg::VAL_W-1:0]       hit_data
);

    localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

    logic [pidl_pkg::VAL_W-1:0] data_reg;
    logic [pidl_pkg::VAL_W-1:0] data_next;

    // An insert loads the new value at the target slot and pulls from the
    // left above it; a delete pulls from the right at and above the target.
    always_comb begin
        data_next = data_reg;
        priority if (cmd.do_insert && (pos == MY_INDEX)) begin
            data_next = ins_value;
        end else if (cmd.do_insert && (pos < MY_INDEX)) begin
            data_next = left_data;
        end else if (cmd.do_delete && (pos <= MY_INDEX)) begin
            data_next = right_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (pos == MY_INDEX) ? data_reg : '0;

endmodule : pidl_cell
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/delete list unit.
// ----------------------------------------------------------------------------
// Operations go in on the s_ stream and results come back on the m_ stream.
// A behavioral copy of the list, kept inside the bench, works out the
// expected status, removed value and length for every accepted operation.
// Those expectations wait in order until the matching result beat arrives.
// A short directed table comes first. It covers the empty list, a bad
// position, the value extremes and a full list. A long random run follows
// in four idle and stall patterns. Its content is shaped so that the list
// fills up and drains again many times over.
// ----------------------------------------------------------------------------
module tb_top;
    import pidl_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int CLK_HALF    = 5;
    localparam int RESET_TICKS = 9;
    localparam int PHASE_ITEMS = 320;
    localparam int REPORT_MAX  = 10;

    // One result beat, unpacked into its fields.
    typedef struct packed {
        status_t            status;
        logic signed [31:0] removed;
        logic [LEN_W-1:0]   length;
    } list_result_t;

    // One row of the directed table. When has_res is set, the result is typed
    // in by hand and replaces the behavioral prediction for that beat.
    typedef struct packed {
        logic               op;
        logic [POS_W-1:0]   pos;
        logic [VAL_W-1:0]   val;
        bit                 has_res;
        list_result_t       res;
    } op_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // The hand-typed expectation for the beat now on the input bus. It is driven
    // together with s_tdata, so it is always read along with its own beat.
    bit           row_has_res = 1'b0;
    list_result_t row_res     = '0;

    // This is the bench's own copy of the list, updated on every accepted beat.
    logic signed [31:0] mirror_vals [LIST_DEPTH];
    int                 mirror_len = 0;

    // These are the results that are still expected on m_, oldest first.
    list_result_t pending_results [$];

    // The sender uses this count to aim positions. It follows the beats that
    // have been handed over, not the beats that the monitor has seen.
    int planned_len = 0;

    // These set the current idle and stall pattern, in percent per cycle.
    int idle_pct  = 0;
    int stall_pct = 0;

    int mismatch_count = 0;
    int ops_accepted   = 0;
    int inserts_sent   = 0;
    int deletes_sent   = 0;
    int results_seen   = 0;
    int peak_length    = 0;
    int status_seen [4];

    op_row_t directed_ops [25];

    positional_insert_delete_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // Apply one operation to the list copy and return the result it gives.
    // An insert opens a gap at the position. A delete closes the gap and
    // hands back the value that it removed. A failed operation changes nothing.
    function automatic list_result_t list_apply(logic op, logic [POS_W-1:0] pos,
                                                logic [VAL_W-1:0] val);
        list_result_t res;
        int           p;
        res = '0;
        res.status = ST_OK;
        p = int'(pos);
        if (op == OP_INSERT) begin
            // A position past the end is checked before a full list.
            if (p > mirror_len) begin
                res.status = ST_INVALID;
            end else if (mirror_len >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                for (int i = mirror_len; i > p; i--) mirror_vals[i] = mirror_vals[i-1];
                mirror_vals[p] = val;
                mirror_len++;
            end
        end else begin
            // An empty list is reported whatever the position is.
            if (mirror_len == 0) begin
                res.status = ST_EMPTY;
            end else if (p >= mirror_len) begin
                res.status = ST_INVALID;
            end else begin
                res.removed = mirror_vals[p];
                for (int i = p; i < mirror_len - 1; i++) mirror_vals[i] = mirror_vals[i+1];
                mirror_len--;
            end
        end
        res.length = mirror_len[LEN_W-1:0];
        return res;
    endfunction

    // Put one operation on the input bus and hold it until the block takes
    // it. Idle cycles come first, according to the current pattern. This way
    // s_tvalid gets exactly one update in each time step.
    task automatic send_op(logic op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           bit has_res, list_result_t res);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {3'b000, val, pos};
        s_tuser     <= op;
        row_has_res <= has_res;
        row_res     <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_INSERT) begin
            inserts_sent++;
            if (pos <= planned_len && planned_len < LIST_DEPTH) planned_len++;
        end else begin
            deletes_sent++;
            if (planned_len != 0 && pos < planned_len) planned_len--;
        end
    endtask

    // Hold the sender until every result that is still owed has come back.
    // The first wait lets the monitor log the beat accepted at this edge.
    task automatic drain_results;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // The receiver stalls at random, one decision per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // The monitor samples both channels at the clock edge. The result beat is
    // checked before the input beat of the same edge is predicted. Since the
    // result is registered, a result can never belong to an input beat that is
    // accepted at that same edge.
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status  = status_t'(m_tuser);
                got.removed = m_tdata[31:0];
                got.length  = m_tdata[36:32];
                results_seen++;
                status_seen[got.status]++;
                if (int'(got.length) > peak_length) peak_length = int'(got.length);
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: result beat with nothing expected: st=%s rm=%0d len=%0d",
                                 $realtime, got.status.name(), got.removed, got.length);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.removed !== want.removed ||
                        got.length !== want.length) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"%0t: mismatch: expected st=%s rm=%0d len=%0d, ",
                                      "got st=%s rm=%0d len=%0d"}, $realtime,
                                     want.status.name(), want.removed, want.length,
                                     got.status.name(), got.removed, got.length);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ops_accepted++;
                want = list_apply(s_tuser[0], s_tdata[4:0], s_tdata[36:5]);
                if (row_has_res) want = row_res;
                pending_results.push_back(want);
            end
        end
    end

    // A run that hangs is ended here. The bound is many times the slowest
    // correct run: about 1300 beats, each facing a long idle gap on the
    // sender side and a long stall on the receiver side.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic             op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        bit               filling;
        int               pick;

        // The directed table starts on a fresh list. Rows typed by hand carry
        // outcomes that can be read straight off the rules. The fill-up rows
        // are left to the prediction.
        directed_ops[0]  = '{OP_DELETE, 5'd0,  32'h0, 1'b1, '{ST_EMPTY,   32'sd0, 5'd0}};
        directed_ops[1]  = '{OP_DELETE, 5'd16, 32'h0, 1'b1, '{ST_EMPTY,   32'sd0, 5'd0}};
        directed_ops[2]  = '{OP_INSERT, 5'd1,  32'h1, 1'b1, '{ST_INVALID, 32'sd0, 5'd0}};
        directed_ops[3]  = '{OP_INSERT, 5'd0,  32'h8000_0000, 1'b1, '{ST_OK, 32'sd0, 5'd1}};
        directed_ops[4]  = '{OP_INSERT, 5'd1,  32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'sd0, 5'd2}};
        directed_ops[5]  = '{OP_INSERT, 5'd0,  32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'sd0, 5'd3}};
        directed_ops[6]  = '{OP_DELETE, 5'd3,  32'h0, 1'b1, '{ST_INVALID, 32'sd0, 5'd3}};
        // The list now holds -1, the most negative value and the most positive
        // value, in that order.
        directed_ops[7]  = '{OP_DELETE, 5'd1,  32'hFFFF_FFFF, 1'b1,
                             '{ST_OK, -32'sd2147483648, 5'd2}};
        // Fill the list to the top with positions spread across it.
        directed_ops[8]  = '{OP_INSERT, 5'd2,  32'h0000_0001, 1'b0, '0};
        directed_ops[9]  = '{OP_INSERT, 5'd0,  32'hAAAA_AAAA, 1'b0, '0};
        directed_ops[10] = '{OP_INSERT, 5'd1,  32'h5555_5555, 1'b0, '0};
        directed_ops[11] = '{OP_INSERT, 5'd5,  32'h0000_0000, 1'b0, '0};
        directed_ops[12] = '{OP_INSERT, 5'd3,  32'h1234_5678, 1'b0, '0};
        directed_ops[13] = '{OP_INSERT, 5'd0,  32'hFEDC_BA98, 1'b0, '0};
        directed_ops[14] = '{OP_INSERT, 5'd8,  32'h7FFF_FFFE, 1'b0, '0};
        directed_ops[15] = '{OP_INSERT, 5'd4,  32'h8000_0001, 1'b0, '0};
        directed_ops[16] = '{OP_INSERT, 5'd10, 32'h0F0F_0F0F, 1'b0, '0};
        directed_ops[17] = '{OP_INSERT, 5'd2,  32'hF0F0_F0F0, 1'b0, '0};
        directed_ops[18] = '{OP_INSERT, 5'd12, 32'h00FF_00FF, 1'b0, '0};
        directed_ops[19] = '{OP_INSERT, 5'd13, 32'hFF00_FF00, 1'b0, '0};
        directed_ops[20] = '{OP_INSERT, 5'd0,  32'h0000_0010, 1'b0, '0};
        directed_ops[21] = '{OP_INSERT, 5'd15, 32'hFFFF_FFFE, 1'b0, '0};
        // With all sixteen cells in use, a valid position still reports full.
        directed_ops[22] = '{OP_INSERT, 5'd16, 32'h1, 1'b1, '{ST_FULL, 32'sd0, 5'd16}};
        directed_ops[23] = '{OP_DELETE, 5'd15, 32'h0, 1'b0, '0};
        directed_ops[24] = '{OP_DELETE, 5'd0,  32'h0, 1'b0, '0};

        repeat (RESET_TICKS) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_ops[i])
            send_op(directed_ops[i].op, directed_ops[i].pos, directed_ops[i].val,
                    directed_ops[i].has_res, directed_ops[i].res);
        s_tvalid <= 1'b0;
        drain_results();

        // Random run in four patterns: no idling, a mostly idle sender, a
        // mostly stalled receiver, and both sides mildly busy. Between the
        // patterns the sender waits until every result is back.
        filling = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The trend swings between filling and draining. This way the
                // full and empty corners keep coming around.
                if (planned_len == LIST_DEPTH) filling = 1'b0;
                else if (planned_len == 0) filling = 1'b1;
                else if ($urandom_range(99) < 3) filling = !filling;

                pick = $urandom_range(99);
                if (pick < 8) begin
                    // Noise: any operation at any legal field value.
                    op  = 1'($urandom_range(1));
                    pos = POS_W'($urandom_range(16));
                end else begin
                    op = (($urandom_range(99) < 75) == filling) ? OP_INSERT : OP_DELETE;
                    if (op == OP_INSERT) begin
                        case ($urandom_range(4))
                            0: pos = '0;
                            1: pos = POS_W'(planned_len);
                            default: pos = POS_W'($urandom_range(planned_len));
                        endcase
                    end else if (planned_len == 0) begin
                        pos = POS_W'($urandom_range(16));
                    end else begin
                        case ($urandom_range(4))
                            0: pos = '0;
                            1: pos = POS_W'(planned_len - 1);
                            default: pos = POS_W'($urandom_range(planned_len - 1));
                        endcase
                    end
                end
                case ($urandom_range(9))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = $urandom_range(7) - 4;
                    default: val = $urandom;
                endcase
                send_op(op, pos, val, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
            drain_results();
        end

        idle_pct  = 0;
        stall_pct = 0;
        drain_results();
        // A stray result beat would show up during this wait after the last one
        // that was expected.
        repeat (8) @(posedge aclk);

        $display("Covered %0d list operations (%0d inserts, %0d deletes), %0d results back.",
                 ops_accepted, inserts_sent, deletes_sent, results_seen);
        $display("Status mix ok/invalid/empty/full: %0d/%0d/%0d/%0d, peak length %0d.",
                 status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], peak_length);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
